[rtl/core/indexed_doubly_linked_list_core_assert.svh]
// assertion macros for the indexed doubly linked list core
`ifndef INDEXED_DOUBLY_LINKED_LIST_CORE_ASSERT_SVH
`define INDEXED_DOUBLY_LINKED_LIST_CORE_ASSERT_SVH

// same-cycle implication
`define IDLL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IDLL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/idll_pkg.sv]
// package: codes and shared types of the indexed doubly linked list core
`default_nettype none
package idll_pkg;

	typedef enum logic [2:0] {
		M_ADD_FIRST  = 3'd0,
		M_ADD_AFTER  = 3'd1,
		M_ADD_BEFORE = 3'd2,
		M_ADD_LAST   = 3'd3,
		M_MOVE_AFTER = 3'd4,
		M_MOVE_LAST  = 3'd5,
		M_READ       = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_UNUSED    = 2'd2,
		STAT_NO_CHANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD1,
		S_RD2,
		S_PLAN,
		S_WRITE,
		S_FIN
	} seq_state_t;

	typedef struct packed {
		logic pay;
		logic prev;
		logic next;
	} field_en_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot_out;
		logic [31:0] payload_out;
		logic [5:0]  prev_out;
		logic        prev_none;
		logic [5:0]  next_out;
		logic        next_none;
		logic [5:0]  head_out;
		logic [5:0]  tail_out;
		logic [6:0]  count_out;
		logic        is_empty;
	} result_t;

	localparam int unsigned N_OPS = 5;

endpackage
`default_nettype wire

[rtl/core/idll_if.sv]
// request and result channel interfaces
`default_nettype none
interface idll_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [5:0]  anchor_slot;
	logic [5:0]  item_slot;
	logic [31:0] payload_in;

	modport source (output valid, mode, anchor_slot, item_slot, payload_in, input ready);
	modport sink (input valid, mode, anchor_slot, item_slot, payload_in, output ready);
endinterface

interface idll_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [5:0]  slot_out;
	logic [31:0] payload_out;
	logic [5:0]  prev_out;
	logic        prev_none;
	logic [5:0]  next_out;
	logic        next_none;
	logic [5:0]  head_out;
	logic [5:0]  tail_out;
	logic [6:0]  count_out;
	logic        is_empty;

	modport source (output valid, status, slot_out, payload_out, prev_out, prev_none,
		next_out, next_none, head_out, tail_out, count_out, is_empty, input ready);
	modport sink (input valid, status, slot_out, payload_out, prev_out, prev_none,
		next_out, next_none, head_out, tail_out, count_out, is_empty, output ready);
endinterface
`default_nettype wire

[rtl/core/idll_mem.sv]
// slot memory: payload, prev and next link per slot, field write enables
`default_nettype none
module idll_mem #(
	parameter int SLOTS = 64,
	parameter int PAYLOAD_BITS = 32,
	localparam int AW = $clog2(SLOTS),
	localparam int LW = $clog2(SLOTS + 1)
) (
	input  wire logic                    clk,
	input  wire idll_pkg::field_en_t     wen,
	input  wire logic [AW-1:0]           waddr,
	input  wire logic [PAYLOAD_BITS-1:0] wpay,
	input  wire logic [LW-1:0]           wprev,
	input  wire logic [LW-1:0]           wnext,
	input  wire logic [AW-1:0]           raddr,
	output logic      [PAYLOAD_BITS-1:0] rpay,
	output logic      [LW-1:0]           rprev,
	output logic      [LW-1:0]           rnext
);
	import idll_pkg::*;

	logic [PAYLOAD_BITS-1:0] pay_mem [SLOTS];
	logic [LW-1:0]           prev_mem [SLOTS];
	logic [LW-1:0]           next_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wen.pay) begin
			pay_mem[waddr] <= wpay;
		end
		if (wen.prev) begin
			prev_mem[waddr] <= wprev;
		end
		if (wen.next) begin
			next_mem[waddr] <= wnext;
		end
	end

	always_ff @(posedge clk) begin
		rpay  <= pay_mem[raddr];
		rprev <= prev_mem[raddr];
		rnext <= next_mem[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/idll_ctrl.sv]
// sequencer: reads linked slots, plans link updates, writes them back
`default_nettype none
module idll_ctrl #(
	parameter int SLOTS = 64,
	parameter int PAYLOAD_BITS = 32,
	localparam int AW = $clog2(SLOTS),
	localparam int LW = $clog2(SLOTS + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	idll_req_if.sink                     req,
	output logic                         res_valid,
	output idll_pkg::result_t            res,
	input  wire logic                    res_ready,
	output idll_pkg::field_en_t          mem_wen,
	output logic      [AW-1:0]           mem_waddr,
	output logic      [PAYLOAD_BITS-1:0] mem_wpay,
	output logic      [LW-1:0]           mem_wprev,
	output logic      [LW-1:0]           mem_wnext,
	output logic      [AW-1:0]           mem_raddr,
	input  wire logic [PAYLOAD_BITS-1:0] mem_rpay,
	input  wire logic [LW-1:0]           mem_rprev,
	input  wire logic [LW-1:0]           mem_rnext
);
	import idll_pkg::*;

	localparam logic [LW-1:0] NONE = LW'(SLOTS);

	seq_state_t state_q, state_nxt;

	logic [2:0]  mode_q;
	logic [5:0]  a_q;
	logic [5:0]  x_q;
	logic [31:0] pay_q;
	logic [LW-1:0] head_q, tail_q, count_q;
	logic [LW-1:0] xp_q, xn_q;
	result_t       res_q;

	logic [N_OPS-1:0] pend_q;
	field_en_t        op_wen_q [N_OPS];
	logic [AW-1:0]    op_addr_q [N_OPS];
	logic [LW-1:0]    op_prev_q [N_OPS];
	logic [LW-1:0]    op_next_q [N_OPS];

	logic [LW-1:0] a_l, x_l, anc_l, first_l, ap, an;
	logic          full, a_in, x_in, is_move;

	// plan outputs
	status_t       p_status;
	logic [LW-1:0] p_slot, p_head, p_tail, p_count;
	logic          p_read, p_pn, p_nn, do_move;
	logic [N_OPS-1:0] p_en;
	field_en_t     p_wen [N_OPS];
	logic [LW-1:0] p_addr [N_OPS];
	logic [LW-1:0] p_prev [N_OPS];
	logic [LW-1:0] p_next [N_OPS];

	logic [2:0]       sel;
	logic [N_OPS-1:0] pend_nxt;

	assign a_l     = LW'(a_q);
	assign x_l     = LW'(x_q);
	assign is_move = (mode_q == M_MOVE_AFTER) || (mode_q == M_MOVE_LAST);
	assign anc_l   = (mode_q == M_MOVE_LAST) ? tail_q : a_l;
	assign first_l = is_move ? x_l : anc_l;
	assign full    = (count_q == NONE);
	assign a_in    = 16'(a_q) < 16'(count_q);
	assign x_in    = 16'(x_q) < 16'(count_q);
	assign ap      = mem_rprev;
	assign an      = mem_rnext;

	always_comb begin
		p_status = STAT_DONE;
		p_slot   = '0;
		p_read   = 1'b0;
		p_pn     = 1'b0;
		p_nn     = 1'b0;
		do_move  = 1'b0;
		p_head   = head_q;
		p_tail   = tail_q;
		p_count  = count_q;
		p_en     = '0;
		for (int j = 0; j < N_OPS; j++) begin
			p_wen[j]  = '0;
			p_addr[j] = '0;
			p_prev[j] = NONE;
			p_next[j] = NONE;
		end
		case (mode_q) inside
			M_ADD_FIRST, M_ADD_LAST: begin
				if (full) begin
					p_status = STAT_FULL;
				end else begin
					p_slot  = count_q;
					p_count = count_q + LW'(1);
					p_en[0] = 1'b1;
					p_wen[0] = '{pay: 1'b1, prev: 1'b1, next: 1'b1};
					p_addr[0] = count_q;
					if (head_q == NONE) begin
						p_head = count_q;
						p_tail = count_q;
					end else if (mode_q == M_ADD_FIRST) begin
						p_next[0] = head_q;
						p_en[1] = 1'b1;
						p_wen[1] = '{pay: 1'b0, prev: 1'b1, next: 1'b0};
						p_addr[1] = head_q;
						p_prev[1] = count_q;
						p_head = count_q;
					end else begin
						p_prev[0] = tail_q;
						p_en[1] = 1'b1;
						p_wen[1] = '{pay: 1'b0, prev: 1'b0, next: 1'b1};
						p_addr[1] = tail_q;
						p_next[1] = count_q;
						p_tail = count_q;
					end
				end
			end
			M_ADD_AFTER, M_ADD_BEFORE: begin
				if (full) begin
					p_status = STAT_FULL;
				end else if (!a_in) begin
					p_status = STAT_UNUSED;
				end else begin
					p_slot  = count_q;
					p_count = count_q + LW'(1);
					p_en[1:0] = 2'b11;
					p_wen[0] = '{pay: 1'b1, prev: 1'b1, next: 1'b1};
					p_addr[0] = count_q;
					p_addr[1] = a_l;
					if (mode_q == M_ADD_AFTER) begin
						p_prev[0] = a_l;
						p_next[0] = an;
						p_wen[1] = '{pay: 1'b0, prev: 1'b0, next: 1'b1};
						p_next[1] = count_q;
						if (an == NONE) begin
							p_tail = count_q;
						end else begin
							p_en[2] = 1'b1;
							p_wen[2] = '{pay: 1'b0, prev: 1'b1, next: 1'b0};
							p_addr[2] = an;
							p_prev[2] = count_q;
						end
					end else begin
						p_prev[0] = ap;
						p_next[0] = a_l;
						p_wen[1] = '{pay: 1'b0, prev: 1'b1, next: 1'b0};
						p_prev[1] = count_q;
						if (ap == NONE) begin
							p_head = count_q;
						end else begin
							p_en[2] = 1'b1;
							p_wen[2] = '{pay: 1'b0, prev: 1'b0, next: 1'b1};
							p_addr[2] = ap;
							p_next[2] = count_q;
						end
					end
				end
			end
			M_MOVE_AFTER: begin
				if (!a_in || !x_in) begin
					p_status = STAT_UNUSED;
				end else begin
					p_slot = x_l;
					if ((a_q == x_q) || (a_l == xp_q)) begin
						p_status = STAT_NO_CHANGE;
					end else begin
						do_move = 1'b1;
					end
				end
			end
			M_MOVE_LAST: begin
				if (!x_in) begin
					p_status = STAT_UNUSED;
				end else begin
					p_slot = x_l;
					if ((x_l == tail_q) || (tail_q == NONE)) begin
						p_status = STAT_NO_CHANGE;
					end else begin
						do_move = 1'b1;
					end
				end
			end
			M_READ: begin
				if (!a_in) begin
					p_status = STAT_UNUSED;
				end else begin
					p_slot = a_l;
					p_read = 1'b1;
					p_pn   = (ap >= NONE);
					p_nn   = (an >= NONE);
				end
			end
			default: begin
				p_status = STAT_NO_CHANGE;
			end
		endcase
		if (do_move) begin
			// unlink the item
			if (x_l == head_q) begin
				p_head = xn_q;
			end else begin
				p_en[0] = 1'b1;
				p_wen[0] = '{pay: 1'b0, prev: 1'b0, next: 1'b1};
				p_addr[0] = xp_q;
				p_next[0] = xn_q;
			end
			if (x_l == tail_q) begin
				p_tail = xp_q;
			end else begin
				p_en[1] = 1'b1;
				p_wen[1] = '{pay: 1'b0, prev: 1'b1, next: 1'b0};
				p_addr[1] = xn_q;
				p_prev[1] = xp_q;
			end
			// relink after the anchor
			p_en[3:2] = 2'b11;
			p_wen[2] = '{pay: 1'b0, prev: 1'b1, next: 1'b1};
			p_addr[2] = x_l;
			p_prev[2] = anc_l;
			p_next[2] = an;
			p_wen[3] = '{pay: 1'b0, prev: 1'b0, next: 1'b1};
			p_addr[3] = anc_l;
			p_next[3] = x_l;
			if (an == NONE) begin
				p_tail = x_l;
			end else begin
				p_en[4] = 1'b1;
				p_wen[4] = '{pay: 1'b0, prev: 1'b1, next: 1'b0};
				p_addr[4] = an;
				p_prev[4] = x_l;
			end
		end
	end

	// lowest pending write first
	always_comb begin
		sel = '0;
		for (int j = N_OPS - 1; j >= 0; j--) begin
			if (pend_q[j]) begin
				sel = 3'(j);
			end
		end
		pend_nxt = pend_q & ~(N_OPS'(1) << sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		req.ready = 1'b0;
		res_valid = 1'b0;
		mem_raddr = anc_l[AW-1:0];
		mem_wen   = '0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_nxt = S_RD1;
				end
			end
			S_RD1: begin
				mem_raddr = first_l[AW-1:0];
				state_nxt = S_RD2;
			end
			S_RD2: begin
				state_nxt = S_PLAN;
			end
			S_PLAN: begin
				state_nxt = (p_en != '0) ? S_WRITE : S_FIN;
			end
			S_WRITE: begin
				mem_wen = op_wen_q[sel];
				if (pend_nxt == '0) begin
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign mem_waddr = op_addr_q[sel][AW-1:0];
	assign mem_wprev = op_prev_q[sel];
	assign mem_wnext = op_next_q[sel];
	assign mem_wpay  = PAYLOAD_BITS'(pay_q);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NONE;
			tail_q  <= NONE;
			count_q <= '0;
			pend_q  <= '0;
		end else begin
			if (state_q == S_PLAN) begin
				head_q  <= p_head;
				tail_q  <= p_tail;
				count_q <= p_count;
				pend_q  <= p_en;
			end else if (state_q == S_WRITE) begin
				pend_q <= pend_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q <= req.mode;
			a_q    <= req.anchor_slot;
			x_q    <= req.item_slot;
			pay_q  <= req.payload_in;
		end
		if (state_q == S_RD2) begin
			xp_q <= mem_rprev;
			xn_q <= mem_rnext;
		end
		if (state_q == S_PLAN) begin
			for (int j = 0; j < N_OPS; j++) begin
				op_wen_q[j]  <= p_wen[j];
				op_addr_q[j] <= p_addr[j][AW-1:0];
				op_prev_q[j] <= p_prev[j];
				op_next_q[j] <= p_next[j];
			end
			res_q.status      <= p_status;
			res_q.slot_out    <= 6'(p_slot);
			res_q.payload_out <= p_read ? 32'(mem_rpay) : 32'd0;
			res_q.prev_out    <= (p_read && !p_pn) ? 6'(ap) : 6'd0;
			res_q.prev_none   <= p_read && p_pn;
			res_q.next_out    <= (p_read && !p_nn) ? 6'(an) : 6'd0;
			res_q.next_none   <= p_read && p_nn;
			res_q.head_out    <= (p_head == NONE) ? 6'd0 : 6'(p_head);
			res_q.tail_out    <= (p_tail == NONE) ? 6'd0 : 6'(p_tail);
			res_q.count_out   <= 7'(p_count);
			res_q.is_empty    <= (p_count == '0);
		end
	end

endmodule
`default_nettype wire

[rtl/core/indexed_doubly_linked_list_core.sv]
// top level: indexed doubly linked list with slot memory and result register
//
// channel | dir | carries
// req     | in  | mode, anchor_slot, item_slot, payload_in
// rsp     | out | status, slot, payload, prev/next links, head, tail, count, is_empty
//
// one request at a time: it reads, plans, then does its slot memory writes (0 to 5)
// one after another through the single write port of the slot memory
// reset clears head, tail and count; the slot memory needs no clearing
// a result waits in the output register while the next request is read
`default_nettype none
`include "indexed_doubly_linked_list_core_assert.svh"
module indexed_doubly_linked_list_core #(
	parameter int SLOTS = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	idll_req_if.sink   req,
	idll_rsp_if.source rsp
);
	import idll_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);

	field_en_t               mem_wen;
	logic [AW-1:0]           mem_waddr, mem_raddr;
	logic [PAYLOAD_BITS-1:0] mem_wpay, mem_rpay;
	logic [LW-1:0]           mem_wprev, mem_wnext, mem_rprev, mem_rnext;

	logic    res_valid, res_ready;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	idll_ctrl #(.SLOTS(SLOTS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.mem_wen   (mem_wen),
		.mem_waddr (mem_waddr),
		.mem_wpay  (mem_wpay),
		.mem_wprev (mem_wprev),
		.mem_wnext (mem_wnext),
		.mem_raddr (mem_raddr),
		.mem_rpay  (mem_rpay),
		.mem_rprev (mem_rprev),
		.mem_rnext (mem_rnext)
	);

	idll_mem #(.SLOTS(SLOTS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_mem (
		.clk   (clk),
		.wen   (mem_wen),
		.waddr (mem_waddr),
		.wpay  (mem_wpay),
		.wprev (mem_wprev),
		.wnext (mem_wnext),
		.raddr (mem_raddr),
		.rpay  (mem_rpay),
		.rprev (mem_rprev),
		.rnext (mem_rnext)
	);

	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.slot_out    = out_q.slot_out;
	assign rsp.payload_out = out_q.payload_out;
	assign rsp.prev_out    = out_q.prev_out;
	assign rsp.prev_none   = out_q.prev_none;
	assign rsp.next_out    = out_q.next_out;
	assign rsp.next_none   = out_q.next_none;
	assign rsp.head_out    = out_q.head_out;
	assign rsp.tail_out    = out_q.tail_out;
	assign rsp.count_out   = out_q.count_out;
	assign rsp.is_empty    = out_q.is_empty;

	`IDLL_ASSERT_NEXT(a_res_held, clk, arst_n, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`IDLL_ASSERT_NEXT(a_one_req, clk, arst_n, req.valid && req.ready, !req.ready, "second request taken while busy")
	`IDLL_ASSERT_NOW(a_no_accept_pending, clk, arst_n, res_valid, !req.ready, "request taken with result pending")

endmodule
`default_nettype wire
